/* hdl/mke_pkg.sv */
`timescale 1ns / 1ps
// Package for the Morse keyer encoder: character map, Morse pattern table,
// microprogram word layout and control ROM. No dependencies.
package mke_pkg;

  localparam int TicksPerSecondDef = 100;

  localparam int UnitW = 5;
  localparam int DurW = 6;
  localparam int DivW = 16;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;
  localparam int PatLenW = 3;
  localparam int PatBitsW = 6;
  localparam int IdxW = 6;

  localparam logic [UnitW-1:0] UnitReset = 5'd5;
  localparam logic [DivW-1:0] DivReset = 16'd2386;
  localparam logic [DurW-1:0] DurMax = 6'd63;

  localparam logic [IdxW-1:0] IdxGap = 6'd36;
  localparam logic [IdxW-1:0] IdxNone = 6'd63;
  localparam logic [IdxW-1:0] IdxLast = 6'd43;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_UNIT  = 2'd0,
    CFG_DIV   = 2'd1,
    CFG_MUTED = 2'd2
  } cfg_idx_t;

  // Microprogram step addresses
  typedef enum logic [1:0] {
    UP_FETCH = 2'd0,
    UP_MARK  = 2'd1,
    UP_SPACE = 2'd2,
    UP_GAP   = 2'd3
  } upc_t;

  typedef enum logic [1:0] {
    DUR_ELEM  = 2'd0,
    DUR_SPACE = 2'd1,
    DUR_LONG  = 2'd2
  } dur_sel_t;

  typedef enum logic [1:0] {
    LAST_NO    = 2'd0,
    LAST_FINAL = 2'd1,
    LAST_YES   = 2'd2
  } last_sel_t;

  typedef enum logic [1:0] {
    JMP_DISPATCH = 2'd0,
    JMP_FINAL    = 2'd1,
    JMP_ALWAYS   = 2'd2
  } jmp_t;

  typedef struct packed {
    logic      in_rdy;
    logic      emit;
    logic      key_on;
    dur_sel_t  dur;
    last_sel_t last_sel;
    logic      shift;
    jmp_t      jmp;
    upc_t      target;
  } ucw_t;

  typedef struct packed {
    logic [PatLenW-1:0]  len;
    logic [PatBitsW-1:0] bits;   // first element at the top bit, 1 = dash
  } pat_t;

  function automatic ucw_t mke_ucode(upc_t step);
    ucw_t w;
    w = '{in_rdy: 1'b0, emit: 1'b0, key_on: 1'b0, dur: DUR_ELEM,
          last_sel: LAST_NO, shift: 1'b0, jmp: JMP_ALWAYS, target: UP_FETCH};
    case (step)
      UP_FETCH: begin
        w.in_rdy = 1'b1;
        w.jmp = JMP_DISPATCH;
      end
      UP_MARK: begin
        w.emit = 1'b1;
        w.key_on = 1'b1;
        w.dur = DUR_ELEM;
        w.target = UP_SPACE;
      end
      UP_SPACE: begin
        w.emit = 1'b1;
        w.dur = DUR_SPACE;
        w.last_sel = LAST_FINAL;
        w.shift = 1'b1;
        w.jmp = JMP_FINAL;
        w.target = UP_FETCH;
      end
      UP_GAP: begin
        w.emit = 1'b1;
        w.dur = DUR_LONG;
        w.last_sel = LAST_YES;
        w.target = UP_FETCH;
      end
      default: w.target = UP_FETCH;
    endcase
    return w;
  endfunction

  // Map a 7-bit code to a pattern index; IdxNone for codes that send nothing
  function automatic logic [IdxW-1:0] mke_index(logic [6:0] c);
    logic [IdxW-1:0] idx;
    idx = IdxNone;
    if (c >= 7'h41 && c <= 7'h5A) idx = IdxW'(c - 7'h41);
    else if (c >= 7'h61 && c <= 7'h7A) idx = IdxW'(c - 7'h61);
    else if (c >= 7'h30 && c <= 7'h39) idx = 6'd26 + IdxW'(c - 7'h30);
    else begin
      case (c)
        7'h01: idx = 6'd37;
        7'h02: idx = 6'd38;
        7'h1B: idx = 6'd39;
        7'h07, 7'h2E: idx = 6'd40;
        7'h3F: idx = 6'd41;
        7'h2F: idx = 6'd42;
        7'h2C: idx = 6'd43;
        7'h09, 7'h0A, 7'h0D, 7'h20: idx = IdxGap;
        default: idx = IdxNone;
      endcase
    end
    return idx;
  endfunction

  function automatic pat_t mke_pattern(logic [IdxW-1:0] idx);
    pat_t p;
    case (idx)
      6'd0:  p = {3'd2, 6'b010000};
      6'd1:  p = {3'd4, 6'b100000};
      6'd2:  p = {3'd4, 6'b101000};
      6'd3:  p = {3'd3, 6'b100000};
      6'd4:  p = {3'd1, 6'b000000};
      6'd5:  p = {3'd4, 6'b001000};
      6'd6:  p = {3'd3, 6'b110000};
      6'd7:  p = {3'd4, 6'b000000};
      6'd8:  p = {3'd2, 6'b000000};
      6'd9:  p = {3'd4, 6'b011100};
      6'd10: p = {3'd3, 6'b101000};
      6'd11: p = {3'd4, 6'b010000};
      6'd12: p = {3'd2, 6'b110000};
      6'd13: p = {3'd2, 6'b100000};
      6'd14: p = {3'd3, 6'b111000};
      6'd15: p = {3'd4, 6'b011000};
      6'd16: p = {3'd4, 6'b110100};
      6'd17: p = {3'd3, 6'b010000};
      6'd18: p = {3'd3, 6'b000000};
      6'd19: p = {3'd1, 6'b100000};
      6'd20: p = {3'd3, 6'b001000};
      6'd21: p = {3'd4, 6'b000100};
      6'd22: p = {3'd3, 6'b011000};
      6'd23: p = {3'd4, 6'b100100};
      6'd24: p = {3'd4, 6'b101100};
      6'd25: p = {3'd4, 6'b110000};
      6'd26: p = {3'd5, 6'b111110};
      6'd27: p = {3'd5, 6'b011110};
      6'd28: p = {3'd5, 6'b001110};
      6'd29: p = {3'd5, 6'b000110};
      6'd30: p = {3'd5, 6'b000010};
      6'd31: p = {3'd5, 6'b000000};
      6'd32: p = {3'd5, 6'b100000};
      6'd33: p = {3'd5, 6'b110000};
      6'd34: p = {3'd5, 6'b111000};
      6'd35: p = {3'd5, 6'b111100};
      6'd37: p = {3'd4, 6'b010100};
      6'd38: p = {3'd5, 6'b100010};
      6'd39: p = {3'd6, 6'b000101};
      6'd40: p = {3'd6, 6'b010101};
      6'd41: p = {3'd6, 6'b001100};
      6'd42: p = {3'd5, 6'b100100};
      6'd43: p = {3'd6, 6'b110011};
      default: p = {3'd0, 6'b000000};
    endcase
    return p;
  endfunction

endpackage

/* hdl/mke_char_if.sv */
`timescale 1ns / 1ps
// Character request channel: valid/ready handshake with one ASCII byte.
// Depends on mke_pkg for nothing but is compiled after it.
interface mke_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

/* hdl/mke_seg_if.sv */
`timescale 1ns / 1ps
// Key segment request channel: valid/ready handshake with one segment.
// Widths follow the segment fields of the keyer encoder.
interface mke_seg_if;
  logic        valid;
  logic        ready;
  logic        key_on;
  logic [5:0]  duration_ticks;
  logic [15:0] tone_divider_out;
  logic        last;

  modport source (output valid, output key_on, output duration_ticks,
                  output tone_divider_out, output last, input ready);
  modport sink (input valid, input key_on, input duration_ticks,
                input tone_divider_out, input last, output ready);
endinterface

/* hdl/morse_keyer_encoder.sv */
`timescale 1ns / 1ps
// Morse keyer encoder top level. Uses mke_pkg, mke_char_if and mke_seg_if.
//
// Each accepted character turns into key on/off segments, one per cycle
// while the output register is not stalled: a character of n elements
// gives 2n segments, a word-gap character one, and a muted or unmapped
// character none. The sequencer is a four-step microprogram that spends
// one step on the character fetch and one step per segment; a stalled
// output register holds the sequencer on its current step. A new character
// is taken only in the fetch step, i.e. after the last segment of the
// previous one is in the output register. The registers are read as each
// segment is built, so write them only while no character is in flight.
module morse_keyer_encoder #(
  parameter int TICKS_PER_SECOND = mke_pkg::TicksPerSecondDef
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mke_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [mke_pkg::CfgDataW-1:0]       cfg_data,
  mke_char_if.sink                           char_in,
  mke_seg_if.source                          seg_out
);
  import mke_pkg::*;

  localparam int UnitMax = TICKS_PER_SECOND / 5;

  // Configuration registers
  logic [UnitW-1:0] unit_ticks;
  logic [DivW-1:0]  tone_divider;
  logic             muted;

  // Sequencer state and datapath
  upc_t                upc, upc_next;
  ucw_t                ucw;
  logic [PatBitsW-1:0] pat_bits;
  logic [PatLenW-1:0]  pat_left;

  // Output register
  logic             seg_valid;
  logic             seg_key_on;
  logic [DurW-1:0]  seg_dur;
  logic [DivW-1:0]  seg_div;
  logic             seg_last;

  logic             out_free;
  logic             fire;
  logic             final_elem;
  logic [IdxW-1:0]  char_idx;
  pat_t             char_pat;
  logic [UnitW-1:0] unit_raw;
  logic [UnitW-1:0] unit;
  logic [UnitW+1:0] unit3;
  logic [DurW-1:0]  dur_one;
  logic [DurW-1:0]  dur_three;
  logic [DurW-1:0]  dur;
  logic             last_bit;
  logic [DivW-1:0]  div_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks   <= UnitReset;
      tone_divider <= DivReset;
      muted        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_UNIT:  unit_ticks   <= cfg_data[UnitW-1:0];
        CFG_DIV:   tone_divider <= cfg_data[DivW-1:0];
        CFG_MUTED: muted        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Control word for the current step
  assign ucw = mke_ucode(upc);

  assign char_idx   = mke_index(char_in.char_code[6:0]);
  assign char_pat   = mke_pattern(char_idx);
  assign final_elem = (pat_left == PatLenW'(1));

  // Clamp the unit and derive one- and three-unit lengths
  assign unit_raw  = (unit_ticks == '0) ? UnitW'(1) : unit_ticks;
  assign unit      = (32'(unit_raw) > UnitMax) ? UnitW'(UnitMax) : unit_raw;
  assign unit3     = {2'b00, unit} + {1'b0, unit, 1'b0};
  assign dur_one   = DurW'(unit);
  assign dur_three = (unit3 > (UnitW+2)'(DurMax)) ? DurMax : unit3[DurW-1:0];
  assign div_eff   = (tone_divider == '0) ? DivW'(1) : tone_divider;

  always_comb begin
    case (ucw.dur)
      DUR_ELEM:  dur = pat_bits[PatBitsW-1] ? dur_three : dur_one;
      DUR_SPACE: dur = final_elem ? dur_three : dur_one;
      DUR_LONG:  dur = dur_three;
      default:   dur = dur_one;
    endcase
  end

  always_comb begin
    case (ucw.last_sel)
      LAST_NO:    last_bit = 1'b0;
      LAST_FINAL: last_bit = final_elem;
      LAST_YES:   last_bit = 1'b1;
      default:    last_bit = 1'b0;
    endcase
  end

  assign out_free = !seg_valid || seg_out.ready;

  // Output block: handshake and step advance
  always_comb begin
    char_in.ready = ucw.in_rdy;
    if (ucw.in_rdy) fire = char_in.valid;
    else if (ucw.emit) fire = out_free;
    else fire = 1'b1;
  end

  // Next-step block
  always_comb begin
    upc_next = upc;
    if (fire) begin
      case (ucw.jmp)
        JMP_DISPATCH: begin
          if (muted || char_idx > IdxLast) upc_next = UP_FETCH;
          else if (char_idx == IdxGap) upc_next = UP_GAP;
          else upc_next = UP_MARK;
        end
        JMP_FINAL:  upc_next = final_elem ? ucw.target : UP_MARK;
        JMP_ALWAYS: upc_next = ucw.target;
        default:    upc_next = UP_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) upc <= UP_FETCH;
    else upc <= upc_next;
  end

  // Pattern shift register and element count
  always_ff @(posedge clk) begin
    if (fire && ucw.in_rdy) begin
      pat_bits <= char_pat.bits;
      pat_left <= char_pat.len;
    end else if (fire && ucw.shift) begin
      pat_bits <= {pat_bits[PatBitsW-2:0], 1'b0};
      pat_left <= pat_left - PatLenW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (fire && ucw.emit) begin
      seg_valid <= 1'b1;
    end else if (seg_out.ready) begin
      seg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ucw.emit) begin
      seg_key_on <= ucw.key_on;
      seg_dur    <= dur;
      seg_div    <= ucw.key_on ? div_eff : '0;
      seg_last   <= last_bit;
    end
  end

  assign seg_out.valid            = seg_valid;
  assign seg_out.key_on           = seg_key_on;
  assign seg_out.duration_ticks   = seg_dur;
  assign seg_out.tone_divider_out = seg_div;
  assign seg_out.last             = seg_last;

endmodule
